// ===== rtl/core/fcsr_pkg.sv =====
// ----------------------------------------------------------------------------
// fcsr_pkg
// Shared types, constants and helpers of the four channel speed ramp unit
// ----------------------------------------------------------------------------
package fcsr_pkg;

  localparam int CHANNELS   = 4;
  localparam int OUT_FIELDS = 4;

  localparam int CMD_W    = 2;
  localparam int CHAN_W   = 2;
  localparam int REQ_W    = 16;
  localparam int STEP_W   = 16;
  localparam int LIMIT_W  = 9;
  localparam int TARGET_W = 10;
  localparam int SPEED_W  = 16;
  localparam int GOAL_W   = 17;
  localparam int DIFF_W   = 18;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STOP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RPM_LIMIT = 1'd1;

  localparam logic [STEP_W-1:0]  RAMP_STEP_RST = 16'd40;
  localparam logic [LIMIT_W-1:0] RPM_LIMIT_RST = 9'd210;
  localparam logic [LIMIT_W-1:0] RPM_LIMIT_MAX = 9'd327;

  localparam logic signed [GOAL_W-1:0] UNITS_PER_RPM = 17'sd100;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [CHAN_W-1:0]       channel;
    logic signed [REQ_W-1:0] requested_rpm;
  } in_item_t;

  typedef struct packed {
    logic [STEP_W-1:0]  ramp_step;
    logic [LIMIT_W-1:0] rpm_limit;
  } cfg_t;

  typedef struct packed {
    logic                       go;
    logic [CMD_W-1:0]           cmd;
    logic                       hit;
    logic signed [TARGET_W-1:0] target;
  } chan_op_t;

  // clamp a requested rpm to plus or minus the effective limit
  function automatic logic signed [TARGET_W-1:0] clamp_rpm(
    input logic signed [REQ_W-1:0] req,
    input logic [LIMIT_W-1:0]      lim
  );
    logic [LIMIT_W-1:0]      lim_eff;
    logic signed [REQ_W-1:0] pos;
    logic signed [REQ_W-1:0] neg;
    logic signed [REQ_W-1:0] res;
    lim_eff = (lim > RPM_LIMIT_MAX) ? RPM_LIMIT_MAX : lim;
    pos     = signed'(REQ_W'(lim_eff));
    neg     = -pos;
    if (req > pos) begin
      res = pos;
    end else if (req < neg) begin
      res = neg;
    end else begin
      res = req;
    end
    return res[TARGET_W-1:0];
  endfunction

endpackage

// ===== rtl/core/fcsr_ifs.sv =====
// ----------------------------------------------------------------------------
// fcsr channel interfaces
// Valid/ready channels for commands, speed reports and register writes
// ----------------------------------------------------------------------------
interface fcsr_in_if;
  import fcsr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [CHAN_W-1:0]       channel;
  logic signed [REQ_W-1:0] requested_rpm;

  modport source (output valid, output cmd, output channel, output requested_rpm,
                  input ready);
  modport sink   (input valid, input cmd, input channel, input requested_rpm,
                  output ready);
endinterface

interface fcsr_out_if;
  import fcsr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] speed_ch0;
  logic signed [SPEED_W-1:0] speed_ch1;
  logic signed [SPEED_W-1:0] speed_ch2;
  logic signed [SPEED_W-1:0] speed_ch3;

  modport source (output valid, output speed_ch0, output speed_ch1,
                  output speed_ch2, output speed_ch3, input ready);
  modport sink   (input valid, input speed_ch0, input speed_ch1,
                  input speed_ch2, input speed_ch3, output ready);
endinterface

interface fcsr_cfg_if;
  import fcsr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/fcsr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fcsr_cfg_regs
// Ramp step and rpm limit registers behind the configuration write channel
// ----------------------------------------------------------------------------
module fcsr_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  fcsr_cfg_if.sink       cfg_if,
  output fcsr_pkg::cfg_t cfg
);
  import fcsr_pkg::*;

  logic [STEP_W-1:0]  ramp_step_r;
  logic [LIMIT_W-1:0] rpm_limit_r;
  logic               wr;

  assign cfg_if.ready = 1'b1;
  assign wr           = cfg_if.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_step_r <= RAMP_STEP_RST;
      rpm_limit_r <= RPM_LIMIT_RST;
    end else if (wr) begin
      unique case (cfg_if.index)
        REG_RAMP_STEP: ramp_step_r <= cfg_if.data[STEP_W-1:0];
        REG_RPM_LIMIT: rpm_limit_r <= cfg_if.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.ramp_step = ramp_step_r;
  assign cfg.rpm_limit = rpm_limit_r;

endmodule

// ===== rtl/core/fcsr_channel.sv =====
// ----------------------------------------------------------------------------
// fcsr_channel
// Target and ramped speed of one motor channel with its slew update
// ----------------------------------------------------------------------------
module fcsr_channel (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fcsr_pkg::chan_op_t                 op,
  input  logic [fcsr_pkg::STEP_W-1:0]        ramp_step,
  output logic signed [fcsr_pkg::SPEED_W-1:0] speed_nxt
);
  import fcsr_pkg::*;

  logic signed [TARGET_W-1:0] target_r, target_nxt;
  logic signed [SPEED_W-1:0]  ramped_r, ramped_nxt;
  logic signed [GOAL_W-1:0]   tgt_ext;
  logic signed [GOAL_W-1:0]   goal;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [DIFF_W-1:0]   step_s;
  logic signed [DIFF_W-1:0]   up;
  logic signed [DIFF_W-1:0]   down;
  logic signed [SPEED_W-1:0]  ramp_val;

  assign tgt_ext = GOAL_W'(target_r);
  assign goal    = tgt_ext * UNITS_PER_RPM;
  assign diff    = DIFF_W'(goal) - DIFF_W'(ramped_r);
  assign step_s  = signed'(DIFF_W'(ramp_step));
  assign up      = DIFF_W'(ramped_r) + step_s;
  assign down    = DIFF_W'(ramped_r) - step_s;

  always_comb begin
    priority if (diff > step_s) begin
      ramp_val = up[SPEED_W-1:0];
    end else if (diff < -step_s) begin
      ramp_val = down[SPEED_W-1:0];
    end else begin
      ramp_val = goal[SPEED_W-1:0];
    end
  end

  always_comb begin
    target_nxt = target_r;
    ramped_nxt = ramped_r;
    if (op.go) begin
      unique case (op.cmd)
        CMD_SET: begin
          if (op.hit) begin
            target_nxt = op.target;
          end
        end
        CMD_STOP: begin
          if (op.hit) begin
            target_nxt = '0;
            ramped_nxt = '0;
          end
        end
        CMD_TICK: ramped_nxt = ramp_val;
        CMD_NONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      ramped_r <= '0;
    end else begin
      target_r <= target_nxt;
      ramped_r <= ramped_nxt;
    end
  end

  assign speed_nxt = ramp_val;

endmodule

// ===== rtl/core/four_channel_speed_ramp_unit.sv =====
// ----------------------------------------------------------------------------
// four_channel_speed_ramp_unit
// Slew rate limiter for the speed setpoints of four motor channels
// ----------------------------------------------------------------------------
// in_if carries commands: set target (rpm clamped to the rpm limit), stop
// (target and speed of one channel to zero) and tick (all channels step
// toward their targets). only a tick produces a transaction on out_if,
// holding the four ramped speeds in 0.01 rpm after the step.
// cfg_if writes the ramp step and the rpm limit; it is always ready and is
// meant to be used while no command is in flight.
// an accepted command is held in an input register until it can move on;
// then the channel logic updates its state and a tick result is loaded
// into the output register, which drives the report.
// throughput is one command per cycle while no tick waits on the single
// output register; in_if accepts while a report waits as long as the input
// register can move on.
// reset clears all targets and speeds to zero, sets the ramp step to
// 0.4 rpm and the limit to 210 rpm. when the receiver stalls, a tick waits
// in the input register and in_if.ready drops until the report is taken.
// ----------------------------------------------------------------------------
module four_channel_speed_ramp_unit (
  input  logic        clk,
  input  logic        rst_n,
  fcsr_in_if.sink     in_if,
  fcsr_out_if.source  out_if,
  fcsr_cfg_if.sink    cfg_if
);
  import fcsr_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_r;
  logic      s1_vld_r;
  logic      s1_res;
  logic      s1_go;
  logic      out_free;
  logic      in_acc;
  logic      out_vld_r;
  chan_op_t  op;
  logic signed [TARGET_W-1:0] clamped;

  logic signed [SPEED_W-1:0] speed_nxt [CHANNELS];
  logic signed [SPEED_W-1:0] field_nxt [OUT_FIELDS];
  logic signed [SPEED_W-1:0] field_r   [OUT_FIELDS];

  fcsr_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  assign s1_res   = s1_vld_r && (s1_r.cmd == CMD_TICK);
  assign out_free = !out_vld_r || out_if.ready;
  assign s1_go    = s1_vld_r && (!s1_res || out_free);
  assign in_if.ready = !s1_vld_r || s1_go;
  assign in_acc   = in_if.valid && in_if.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_go) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.cmd           <= in_if.cmd;
      s1_r.channel       <= in_if.channel;
      s1_r.requested_rpm <= in_if.requested_rpm;
    end
  end

  assign clamped = clamp_rpm(s1_r.requested_rpm, cfg.rpm_limit);

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    chan_op_t op_i;

    always_comb begin
      op_i     = op;
      op_i.hit = (int'(s1_r.channel) == i);
    end

    fcsr_channel u_chan (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (op_i),
      .ramp_step (cfg.ramp_step),
      .speed_nxt (speed_nxt[i])
    );
  end

  assign op.go     = s1_go;
  assign op.cmd    = s1_r.cmd;
  assign op.hit    = 1'b0;
  assign op.target = clamped;

  for (genvar k = 0; k < OUT_FIELDS; k++) begin : g_field
    if (k < CHANNELS) begin : g_live
      assign field_nxt[k] = speed_nxt[k];
    end else begin : g_absent
      assign field_nxt[k] = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_go && s1_res) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_res) begin
      field_r <= field_nxt;
    end
  end

  assign out_if.valid     = out_vld_r;
  assign out_if.speed_ch0 = field_r[0];
  assign out_if.speed_ch1 = field_r[1];
  assign out_if.speed_ch2 = field_r[2];
  assign out_if.speed_ch3 = field_r[3];

endmodule
